[sv/spotlight_pixel_attenuator_defines.svh]
// Assertion macros shared by the spotlight pixel attenuator RTL.
`ifndef SPOTLIGHT_PIXEL_ATTENUATOR_DEFINES_SVH
`define SPOTLIGHT_PIXEL_ATTENUATOR_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define SPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next one.
`define SPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/spa_pkg.sv]
// Shared constants and types of the spotlight pixel attenuator.
package spa_pkg;

  localparam int CHAN_BITS = 8;
  // Fraction bits of the distance-to-radius ratio; one divider step per bit.
  localparam int DIV_STEPS = 16;
  localparam int GAIN_W    = DIV_STEPS + 1;

  localparam logic [GAIN_W-1:0] GAIN_ONE  = 17'h10000;
  localparam logic [GAIN_W-1:0] GAIN_HALF = 17'h08000;
  // 3.5 in the gain format, one bit wider than the gain itself.
  localparam logic [GAIN_W:0]   GAIN_BASE = 18'h38000;

  typedef enum logic [1:0] {
    REG_CENTER_ROW  = 2'd0,
    REG_CENTER_COL  = 2'd1,
    REG_SPOT_RADIUS = 2'd2
  } spa_reg_e;

endpackage

[sv/spa_sqrt_step.sv]
// One registered bit step of the pipelined integer square root.
module spa_sqrt_step #(
  parameter int XW = 42,
  parameter int RW = 21
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [XW-1:0] x_i,
  input  logic [RW:0]   rem_i,
  input  logic [RW-1:0] root_i,
  output logic [XW-1:0] x_o,
  output logic [RW:0]   rem_o,
  output logic [RW-1:0] root_o
);

  logic [RW+1:0] rem_sh;
  logic [RW+1:0] trial;
  logic [RW+1:0] diff;
  logic          ge;

  // The partial remainder never exceeds twice the partial root, so its top
  // bit is zero before the next pair of radicand bits is brought down.
  always_comb begin
    rem_sh = {rem_i[RW-1:0], x_i[XW-1 -: 2]};
    trial  = {root_i, 2'b01};
    ge     = (rem_sh >= trial);
    diff   = rem_sh - trial;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o    <= {x_i[XW-3:0], 2'b00};
      rem_o  <= ge ? diff[RW:0] : rem_sh[RW:0];
      root_o <= {root_i[RW-2:0], ge};
    end
  end

endmodule

[sv/spa_div_step.sv]
// One registered quotient bit of the distance-by-radius divider.
module spa_div_step #(
  parameter int CB = 12
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [CB-1:0]            radius_i,
  input  logic [CB-1:0]            rem_i,
  input  logic [spa_pkg::DIV_STEPS-1:0] num_i,
  input  logic [spa_pkg::DIV_STEPS-1:0] quo_i,
  output logic [CB-1:0]            rem_o,
  output logic [spa_pkg::DIV_STEPS-1:0] num_o,
  output logic [spa_pkg::DIV_STEPS-1:0] quo_o
);

  import spa_pkg::*;

  logic [CB:0] rem_sh;
  logic [CB:0] diff;
  logic        ge;

  always_comb begin
    rem_sh = {rem_i, num_i[DIV_STEPS-1]};
    ge     = (rem_sh >= {1'b0, radius_i});
    diff   = rem_sh - {1'b0, radius_i};
  end

  // The remainder stays below the radius, so CB bits hold it either way.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= ge ? diff[CB-1:0] : rem_sh[CB-1:0];
      num_o <= {num_i[DIV_STEPS-2:0], 1'b0};
      quo_o <= {quo_i[DIV_STEPS-2:0], ge};
    end
  end

endmodule

[sv/spa_lane.sv]
// One colour lane: scales a channel by the gain and truncates the product.
module spa_lane (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [spa_pkg::CHAN_BITS-1:0]  chan_i,
  input  logic [spa_pkg::GAIN_W-1:0]     gain_i,
  output logic [spa_pkg::CHAN_BITS-1:0]  chan_o
);

  import spa_pkg::*;

  logic [CHAN_BITS+GAIN_W-1:0] prod;

  assign prod = {{GAIN_W{1'b0}}, chan_i} * {{CHAN_BITS{1'b0}}, gain_i};

  // The gain never exceeds one, so the kept bits cannot overflow.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      chan_o <= prod[DIV_STEPS +: CHAN_BITS];
    end
  end

endmodule

[sv/spotlight_pixel_attenuator.sv]
// Top level of the spotlight pixel attenuator: pixel pipeline and lanes.
`include "spotlight_pixel_attenuator_defines.svh"

// Dims every pixel outside a configured spotlight circle to one half and fades
// the rim just inside it. The block takes one pixel per clock and delivers one
// pixel per clock while the output is being taken. After the offset, square and
// sum stages come the square-root pipeline, one root bit per stage, and a
// sixteen-stage restoring divider for the distance/radius ratio, then the gain
// stage and the per-channel multiplier lanes. Every stage has its own valid bit
// and bubbles close up, so requests keep flowing while a result waits at the
// output. Write the center and radius only while the pipeline is empty; they are
// read live by the stages.
module spotlight_pixel_attenuator #(
  parameter int COORD_BITS = 12,
  parameter int CHANNELS   = 3
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [COORD_BITS:0]  cfg_data_i,

  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // Fields from bit 0: pixel_row, pixel_col, chan_blue, chan_green, chan_red...
  input  logic [((2*COORD_BITS+8*CHANNELS+7)/8)*8-1:0] s_axis_tdata,

  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // Fields from bit 0: out_blue, out_green, out_red...
  output logic [8*CHANNELS-1:0] m_axis_tdata
);

  import spa_pkg::*;

  localparam int CB     = COORD_BITS;
  localparam int CH_W   = CHAN_BITS * CHANNELS;
  localparam int SUM_W  = 2 * CB + 1;
  localparam int RW     = CB + 9;
  localparam int XW     = 2 * RW;
  localparam int ST_SD  = 3 + RW;
  localparam int ST_SG  = ST_SD + DIV_STEPS + 1;
  localparam int ST_SO  = ST_SG + 1;
  localparam int NST    = ST_SO + 1;

  // Configuration registers.
  logic signed [CB:0] center_row_q;
  logic signed [CB:0] center_col_q;
  logic [CB-1:0]      spot_radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_row_q  <= '0;
      center_col_q  <= '0;
      spot_radius_q <= '0;
    end else if (cfg_we_i) begin
      unique case (spa_reg_e'(cfg_idx_i))
        REG_CENTER_ROW:  center_row_q  <= cfg_data_i;
        REG_CENTER_COL:  center_col_q  <= cfg_data_i;
        REG_SPOT_RADIUS: spot_radius_q <= cfg_data_i[CB-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage loads when some stage at or after it is
  // empty, or when the output is being taken.
  logic [NST-1:0] v_q;
  logic [NST-1:0] v_d;
  logic [NST-1:0] en;

  for (genvar s = 0; s < NST; s++) begin : g_en
    assign en[s] = m_axis_tready | ~(&v_q[NST-1:s]);
  end

  assign v_d = {v_q[NST-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (en & v_d) | (~en & v_q);
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v_q[ST_SO];

  // Side-band carried along with each pixel.
  logic [CH_W-1:0] chan_q   [0:ST_SG];
  logic            inside_q [0:ST_SG-1];

  for (genvar s = 1; s <= ST_SG; s++) begin : g_chan
    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        chan_q[s] <= chan_q[s-1];
      end
    end
  end

  for (genvar s = 1; s < ST_SG; s++) begin : g_inside
    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        inside_q[s] <= inside_q[s-1];
      end
    end
  end

  // Stage 0: absolute offsets from the center and the square test.
  logic signed [CB+1:0] row_s;
  logic signed [CB+1:0] col_s;
  logic signed [CB+1:0] dr_s;
  logic signed [CB+1:0] dc_s;
  logic signed [CB+1:0] dr_n;
  logic signed [CB+1:0] dc_n;
  logic [CB:0]          dr_mag;
  logic [CB:0]          dc_mag;
  logic                 in_square;
  logic [CB-1:0]        dr_q;
  logic [CB-1:0]        dc_q;

  always_comb begin
    row_s     = $signed({2'b00, s_axis_tdata[CB-1:0]});
    col_s     = $signed({2'b00, s_axis_tdata[2*CB-1:CB]});
    dr_s      = row_s - {center_row_q[CB], center_row_q};
    dc_s      = col_s - {center_col_q[CB], center_col_q};
    dr_n      = -dr_s;
    dc_n      = -dc_s;
    dr_mag    = dr_s[CB+1] ? dr_n[CB:0] : dr_s[CB:0];
    dc_mag    = dc_s[CB+1] ? dc_n[CB:0] : dc_s[CB:0];
    in_square = (dr_mag < {1'b0, spot_radius_q}) && (dc_mag < {1'b0, spot_radius_q});
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      dr_q        <= dr_mag[CB-1:0];
      dc_q        <= dc_mag[CB-1:0];
      inside_q[0] <= in_square;
      chan_q[0]   <= s_axis_tdata[2*CB +: CH_W];
    end
  end

  // Stage 1: squares. Stage 2: sum, scaled to give eight fraction bits of root.
  logic [2*CB-1:0] sqr_r_q;
  logic [2*CB-1:0] sqr_c_q;
  logic [SUM_W-1:0] sum;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      sqr_r_q <= {{CB{1'b0}}, dr_q} * {{CB{1'b0}}, dr_q};
      sqr_c_q <= {{CB{1'b0}}, dc_q} * {{CB{1'b0}}, dc_q};
    end
  end

  assign sum = {1'b0, sqr_r_q} + {1'b0, sqr_c_q};

  logic [XW-1:0] sq_x    [0:RW];
  logic [RW:0]   sq_rem  [0:RW];
  logic [RW-1:0] sq_root [0:RW];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      sq_x[0] <= {1'b0, sum, 16'b0};
    end
  end

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    spa_sqrt_step #(
      .XW (XW),
      .RW (RW)
    ) u_sqrt_step (
      .clk_i  (clk_i),
      .en_i   (en[3+k]),
      .x_i    (sq_x[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .x_o    (sq_x[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1])
    );
  end

  // Divider setup: a ratio of one or more saturates, otherwise the quotient
  // has sixteen bits and the high dividend part is already below the radius.
  logic [CB-1:0]        div_rem [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] div_num [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] div_quo [0:DIV_STEPS];
  logic                 sat_q   [0:DIV_STEPS];
  logic [RW-1:0]        root;

  assign root = sq_root[RW];

  always_ff @(posedge clk_i) begin
    if (en[ST_SD]) begin
      sat_q[0]   <= (root >= {1'b0, spot_radius_q, 8'b0});
      div_rem[0] <= root[8 +: CB];
      div_num[0] <= {root[7:0], 8'b0};
    end
  end

  assign div_quo[0] = '0;

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    spa_div_step #(
      .CB (CB)
    ) u_div_step (
      .clk_i    (clk_i),
      .en_i     (en[ST_SD+1+j]),
      .radius_i (spot_radius_q),
      .rem_i    (div_rem[j]),
      .num_i    (div_num[j]),
      .quo_i    (div_quo[j]),
      .rem_o    (div_rem[j+1]),
      .num_o    (div_num[j+1]),
      .quo_o    (div_quo[j+1])
    );

    always_ff @(posedge clk_i) begin
      if (en[ST_SD+1+j]) begin
        sat_q[j+1] <= sat_q[j];
      end
    end
  end

  // Gain stage: min(3.5 - 3 * ratio, 1), or one half outside the square.
  logic [GAIN_W-1:0] ratio;
  logic [GAIN_W:0]   ratio3;
  logic [GAIN_W:0]   gain_raw;
  logic [GAIN_W-1:0] gain_d;
  logic [GAIN_W-1:0] gain_q;

  always_comb begin
    ratio    = sat_q[DIV_STEPS] ? GAIN_ONE : {1'b0, div_quo[DIV_STEPS]};
    ratio3   = {ratio, 1'b0} + {1'b0, ratio};
    gain_raw = GAIN_BASE - ratio3;
    if (!inside_q[ST_SG-1]) begin
      gain_d = GAIN_HALF;
    end else if (gain_raw > {1'b0, GAIN_ONE}) begin
      gain_d = GAIN_ONE;
    end else begin
      gain_d = gain_raw[GAIN_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_SG]) begin
      gain_q <= gain_d;
    end
  end

  // Channel lanes; their output registers together form the result.
  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    spa_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en[ST_SO]),
      .chan_i (chan_q[ST_SG][c*CHAN_BITS +: CHAN_BITS]),
      .gain_i (gain_q),
      .chan_o (m_axis_tdata[c*CHAN_BITS +: CHAN_BITS])
    );
  end

  // The input stalls only when every stage holds a pixel and the output is held.
  `SPA_ASSERT(a_stall_only_full, s_axis_tready || !m_axis_tready, "input stalled while output taken")
  `SPA_ASSERT(a_stall_full, s_axis_tready || (&v_q), "input stalled while a stage is empty")
  `SPA_ASSERT_NEXT(a_outside_half, v_q[ST_SG-1] && !inside_q[ST_SG-1] && en[ST_SG], gain_q == GAIN_HALF, "outside pixel not halved")
  `SPA_ASSERT(a_gain_range, !v_q[ST_SG] || (gain_q >= GAIN_HALF && gain_q <= GAIN_ONE), "gain out of range")
  `SPA_ASSERT(a_div_rem, !(v_q[ST_SG-1] && inside_q[ST_SG-1] && !sat_q[DIV_STEPS]) || (div_rem[DIV_STEPS] < spot_radius_q), "divider remainder not below radius")

endmodule
